// ===== design/tlru_pkg.sv =====
// shared types and constants for the true-lru replacement block
package tlru_pkg;

    localparam int SET_IDX_W = 10;
    localparam int WAY_W     = 4;
    localparam int MASK_W    = 16;
    localparam int BIT_CNT_W = 4;

    localparam logic OP_QUERY  = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    typedef struct packed {
        logic                 opcode;
        logic [SET_IDX_W-1:0] set_index;
        logic [WAY_W-1:0]     way;
        logic [MASK_W-1:0]    valid_mask;
        logic                 is_writeback;
        logic                 hit;
    } req_t;

    typedef struct packed {
        logic [WAY_W-1:0] victim_way;
        logic             no_victim;
    } rsp_t;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic red_step;
        logic mem_rd;
        logic exec;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic red_last;
    } status_t;

endpackage

// ===== design/tlru_ctrl.sv =====
// sequencer for clearing, set reduction, row read and execute
module tlru_ctrl
    import tlru_pkg::*;
#(
    parameter int SETS = 1024
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy
);

    localparam bit DIRECT = (SETS >= (2 ** SET_IDX_W)) || ((SETS & (SETS - 1)) == 0);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_REDUCE = 3'd2;
    localparam logic [2:0] S_READ   = 3'd3;
    localparam logic [2:0] S_EXEC   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = DIRECT ? S_READ : S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                cmd.red_step = 1'b1;
                if (status.red_last)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== design/tlru_datapath.sv =====
// rank memory, set reduction, victim search and promote logic
module tlru_datapath
    import tlru_pkg::*;
#(
    parameter int WAYS = 16,
    parameter int SETS = 1024
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  req_t    req,
    input  cmd_t    cmd,
    output status_t status,
    output rsp_t    rsp,
    output logic    rsp_valid
);

    localparam int RW    = $clog2(WAYS);
    localparam int SW    = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int ROW_W = WAYS * RW;
    localparam bit DIRECT = (SETS >= (2 ** SET_IDX_W)) || ((SETS & (SETS - 1)) == 0);

    logic [ROW_W-1:0] mem [SETS];

    req_t                 req_reg;
    logic [SW-1:0]        set_reg;
    logic [SW-1:0]        set_next;
    logic [BIT_CNT_W-1:0] red_cnt_reg;
    logic [BIT_CNT_W-1:0] red_cnt_next;
    logic [SW-1:0]        clr_cnt_reg;
    logic [ROW_W-1:0]     row_reg;
    rsp_t                 rsp_reg;
    rsp_t                 rsp_next;
    logic                 rsp_valid_reg;

    logic [31:0]      idx_ext;
    logic [SW-1:0]    set_direct;
    logic [SW:0]      trial;
    logic [ROW_W-1:0] init_row;
    logic [ROW_W-1:0] new_row;
    logic [RW-1:0]    cur_rank;
    logic [31:0]      mask_ext;
    logic             found_inv;
    logic             found_old;
    logic [4:0]       inv_idx;
    logic [4:0]       old_idx;
    logic             upd_en;
    logic             mem_we;
    logic [SW-1:0]    mem_waddr;
    logic [ROW_W-1:0] mem_wdata;

    // set index reduced mod SETS, one bit per step if under 1024 and not a power of 2
    always_comb
    begin
        idx_ext    = 32'(req.set_index);
        set_direct = (SETS == 1) ? '0 : idx_ext[SW-1:0];
        trial      = {set_reg, req_reg.set_index[red_cnt_reg]};
        if (trial >= (SW+1)'(SETS))
        begin
            trial = trial - (SW+1)'(SETS);
        end
        set_next     = set_reg;
        red_cnt_next = red_cnt_reg;
        if (cmd.load)
        begin
            set_next     = DIRECT ? set_direct : '0;
            red_cnt_next = BIT_CNT_W'(SET_IDX_W - 1);
        end
        else if (cmd.red_step)
        begin
            set_next     = trial[SW-1:0];
            red_cnt_next = red_cnt_reg - 1'b1;
        end
    end

    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            init_row[i*RW +: RW] = RW'(i);
        end
    end

    // victim: lowest invalid way, else the oldest-rank way, else no_victim
    always_comb
    begin
        mask_ext  = {16'hFFFF, req_reg.valid_mask};
        found_inv = 1'b0;
        found_old = 1'b0;
        inv_idx   = '0;
        old_idx   = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (!mask_ext[i])
            begin
                found_inv = 1'b1;
                inv_idx   = 5'(i);
            end
            if (row_reg[i*RW +: RW] == RW'(WAYS - 1))
            begin
                found_old = 1'b1;
                old_idx   = 5'(i);
            end
        end
        rsp_next = '0;
        if (found_inv)
        begin
            rsp_next.victim_way = inv_idx[WAY_W-1:0];
        end
        else if (found_old)
        begin
            rsp_next.victim_way = old_idx[WAY_W-1:0];
        end
        else
        begin
            rsp_next.no_victim = 1'b1;
        end
    end

    // promote: accessed way to rank 0, younger ways age by one
    always_comb
    begin
        cur_rank = '0;
        for (int i = 0; i < WAYS; i++)
        begin
            if (32'(req_reg.way) == i)
            begin
                cur_rank = row_reg[i*RW +: RW];
            end
        end
        for (int i = 0; i < WAYS; i++)
        begin
            if (32'(req_reg.way) == i)
            begin
                new_row[i*RW +: RW] = '0;
            end
            else if (row_reg[i*RW +: RW] < cur_rank)
            begin
                new_row[i*RW +: RW] = row_reg[i*RW +: RW] + 1'b1;
            end
            else
            begin
                new_row[i*RW +: RW] = row_reg[i*RW +: RW];
            end
        end
        upd_en = (req_reg.opcode == OP_UPDATE)
               && !(req_reg.is_writeback && req_reg.hit)
               && (32'(req_reg.way) < WAYS);
    end

    assign mem_we    = cmd.clr_step || (cmd.exec && upd_en);
    assign mem_waddr = cmd.clr_step ? clr_cnt_reg : set_reg;
    assign mem_wdata = cmd.clr_step ? init_row : new_row;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.mem_rd)
        begin
            row_reg <= mem[set_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        set_reg     <= set_next;
        red_cnt_reg <= red_cnt_next;
        if (cmd.exec)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            rsp_valid_reg <= cmd.exec && (req_reg.opcode == OP_QUERY);
        end
    end

    assign status.clr_last = (clr_cnt_reg == SW'(SETS - 1));
    assign status.red_last = (red_cnt_reg == '0);
    assign rsp             = rsp_reg;
    assign rsp_valid       = rsp_valid_reg;

endmodule

// ===== design/true_lru_replacement.sv =====
// true-lru replacement: an item steps through load, row read, execute and back to idle,
// and no new item is taken until idle; with SETS below 1024 and not a power of two, a
// bit-serial set reduction runs between load and read. a query result is registered on
// rsp and held until the next execute. after reset the block is busy while each rank row
// is set to its way index. the receiver cannot stall; rsp_valid is a one-cycle strobe.
module true_lru_replacement
    import tlru_pkg::*;
#(
    parameter int WAYS = 16,
    parameter int SETS = 1024
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output rsp_t rsp,
    output logic rsp_valid
);

    cmd_t    cmd;
    status_t status;

    tlru_ctrl #(
        .SETS (SETS)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    tlru_datapath #(
        .WAYS (WAYS),
        .SETS (SETS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .status    (status),
        .rsp       (rsp),
        .rsp_valid (rsp_valid)
    );

    // an accepted item keeps the block busy for the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after item accepted");

    // results are never back to back
    a_rsp_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |=> !rsp_valid)
        else $error("result strobe held for two cycles");

    // a result only follows a busy cycle
    a_rsp_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> $past(busy))
        else $error("result without work in progress");

    // error answer carries way zero
    a_no_victim_way: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.no_victim) |-> (rsp.victim_way == '0))
        else $error("error result with nonzero way");

endmodule

// ===== tb/tb.sv =====
// testbench for the true-lru replacement block: directed rows, then random traffic
module tb;
    import tlru_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_WAYS  = 16;
    localparam int NUM_SETS  = 1024;
    localparam int NUM_RAND  = 1500;
    localparam int PLAN_LEN  = 24;
    localparam int DRAIN_CYC = 20;

    typedef struct packed {
        req_t r;
        logic typed;
        rsp_t exp;
    } plan_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    req_t req   = '0;
    rsp_t rsp;
    logic rsp_valid;

    logic [WAY_W-1:0] way_rank [NUM_SETS][NUM_WAYS];
    rsp_t             pending_victims [$];
    int               mismatches = 0;
    plan_row_t        plan [PLAN_LEN];

    always #5 clk = ~clk;

    true_lru_replacement #(
        .WAYS (NUM_WAYS),
        .SETS (NUM_SETS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid)
    );

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // expected results wait here in issue order
    function automatic void queue_victim(input rsp_t v);
        pending_victims = {pending_victims, v};
    endfunction

    function automatic rsp_t pick_victim(input logic [SET_IDX_W-1:0] set_raw,
                                         input logic [MASK_W-1:0] mask);
        int   s;
        logic valid;
        rsp_t res;
        s = int'(set_raw) % NUM_SETS;
        for (int i = 0; i < NUM_WAYS; i++)
        begin
            valid = (i < MASK_W) ? mask[i] : 1'b1;
            if (!valid)
            begin
                res.victim_way = WAY_W'(i);
                res.no_victim  = 1'b0;
                return res;
            end
        end
        for (int i = 0; i < NUM_WAYS; i++)
        begin
            if (way_rank[s][i] == WAY_W'(NUM_WAYS - 1))
            begin
                res.victim_way = WAY_W'(i);
                res.no_victim  = 1'b0;
                return res;
            end
        end
        res.victim_way = '0;
        res.no_victim  = 1'b1;
        return res;
    endfunction

    function automatic void touch_way(input req_t r);
        int               s;
        logic [WAY_W-1:0] cur;
        if (r.is_writeback && r.hit)
            return;
        if (int'(r.way) >= NUM_WAYS)
            return;
        s   = int'(r.set_index) % NUM_SETS;
        cur = way_rank[s][r.way];
        for (int i = 0; i < NUM_WAYS; i++)
        begin
            if (way_rank[s][i] < cur)
                way_rank[s][i] = way_rank[s][i] + 1'b1;
        end
        way_rank[s][r.way] = '0;
    endfunction

    function automatic plan_row_t mk(input logic op, input int set_idx, input int w,
                                     input logic [MASK_W-1:0] mask, input logic wb,
                                     input logic h, input logic typed, input int vw);
        plan_row_t row;
        row.r.opcode         = op;
        row.r.set_index      = SET_IDX_W'(set_idx);
        row.r.way            = WAY_W'(w);
        row.r.valid_mask     = mask;
        row.r.is_writeback   = wb;
        row.r.hit            = h;
        row.typed            = typed;
        row.exp.victim_way   = WAY_W'(vw);
        row.exp.no_victim    = 1'b0;
        return row;
    endfunction

    // hold start until the block takes the item
    task automatic issue(input req_t r);
        req   <= r;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic req_t random_item(input logic [SET_IDX_W-1:0] hot_sets [8]);
        req_t r;
        int   roll;
        r.opcode       = ($urandom_range(0, 99) < 60) ? OP_UPDATE : OP_QUERY;
        r.set_index    = ($urandom_range(0, 99) < 70) ? hot_sets[$urandom_range(0, 7)]
                                                      : SET_IDX_W'($urandom);
        r.way          = WAY_W'($urandom);
        r.is_writeback = 1'($urandom_range(0, 1));
        r.hit          = 1'($urandom_range(0, 1));
        roll           = $urandom_range(0, 99);
        // mostly full sets so the rank order decides the victim
        if (roll < 60)
            r.valid_mask = '1;
        else if (roll < 80)
            r.valid_mask = ~(MASK_W'(1) << $urandom_range(0, MASK_W - 1));
        else
            r.valid_mask = MASK_W'($urandom);
        return r;
    endfunction

    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid)
        begin
            if (pending_victims.size() == 0)
            begin
                report_mismatch("result count", 1, 0);
            end
            else
            begin
                want = pending_victims.pop_front();
                if (rsp.victim_way !== want.victim_way)
                    report_mismatch("victim_way", int'(rsp.victim_way),
                                    int'(want.victim_way));
                if (rsp.no_victim !== want.no_victim)
                    report_mismatch("no_victim", int'(rsp.no_victim),
                                    int'(want.no_victim));
            end
        end
    end

    initial
    begin
        logic [SET_IDX_W-1:0] hot_sets [8];
        req_t                 r;
        int                   gap;
        int                   burst;

        for (int s = 0; s < NUM_SETS; s++)
            for (int i = 0; i < NUM_WAYS; i++)
                way_rank[s][i] = WAY_W'(i);
        for (int k = 0; k < 8; k++)
            hot_sets[k] = SET_IDX_W'($urandom);
        burst = 0;

        plan = '{
            mk(OP_QUERY,  0,    0,  16'hFFFF, 0, 0, 1, 15),
            mk(OP_QUERY,  1023, 0,  16'hFFFF, 0, 0, 1, 15),
            mk(OP_QUERY,  0,    0,  16'h0000, 0, 0, 1, 0),
            mk(OP_QUERY,  512,  15, 16'h7FFF, 1, 1, 1, 15),
            mk(OP_QUERY,  341,  0,  16'hFFF7, 0, 0, 1, 3),
            mk(OP_QUERY,  682,  0,  16'hFFFE, 0, 0, 1, 0),
            mk(OP_QUERY,  1023, 0,  16'h8000, 0, 0, 1, 0),
            mk(OP_UPDATE, 0,    15, 16'h0000, 0, 0, 0, 0),
            mk(OP_QUERY,  0,    0,  16'hFFFF, 0, 0, 0, 0),
            // writeback hit leaves the order alone
            mk(OP_UPDATE, 0,    14, 16'hFFFF, 1, 1, 0, 0),
            mk(OP_QUERY,  0,    0,  16'hFFFF, 0, 0, 0, 0),
            mk(OP_UPDATE, 0,    14, 16'h0000, 1, 0, 0, 0),
            mk(OP_QUERY,  0,    0,  16'hFFFF, 0, 0, 0, 0),
            mk(OP_UPDATE, 0,    13, 16'h0000, 0, 1, 0, 0),
            mk(OP_QUERY,  0,    0,  16'hFFFF, 0, 0, 0, 0),
            // way already at rank 0: nothing ages
            mk(OP_UPDATE, 1023, 0,  16'h0000, 0, 0, 0, 0),
            mk(OP_QUERY,  1023, 0,  16'hFFFF, 0, 0, 0, 0),
            mk(OP_UPDATE, 1023, 15, 16'h0000, 0, 0, 0, 0),
            mk(OP_QUERY,  1023, 0,  16'hFFFF, 0, 0, 0, 0),
            mk(OP_UPDATE, 0,    15, 16'h0000, 0, 0, 0, 0),
            mk(OP_QUERY,  0,    0,  16'h7FFF, 0, 0, 1, 15),
            mk(OP_QUERY,  0,    0,  16'hFFFF, 0, 0, 0, 0),
            mk(OP_UPDATE, 5,    7,  16'h0000, 0, 1, 0, 0),
            mk(OP_QUERY,  5,    0,  16'hFFFF, 0, 0, 0, 0)
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (int n = 0; n < PLAN_LEN + NUM_RAND; n++)
        begin
            if (n < PLAN_LEN)
                r = plan[n].r;
            else
                r = random_item(hot_sets);
            issue(r);
            if (r.opcode == OP_QUERY)
            begin
                if (n < PLAN_LEN && plan[n].typed)
                    queue_victim(plan[n].exp);
                else
                    queue_victim(pick_victim(r.set_index, r.valid_mask));
            end
            else
                touch_way(r);

            // occasional back-to-back stretches with no gaps at all
            if (burst == 0 && $urandom_range(0, 49) == 0)
                burst = $urandom_range(20, 60);
            if (burst > 0)
            begin
                burst--;
                gap = 0;
            end
            else
                gap = pick_gap();
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        start <= 1'b0;

        while (pending_victims.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
